>>> rtl/nnpm_pkg.sv
// shared types, constants and codes for the normalized nearest point match unit
// no dependencies; imported by every rtl file of the block
package nnpm_pkg;

	localparam int ENTRIES  = 1024;
	localparam int TAG_BITS = 16;

	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int IN_IDX_W  = 10;
	localparam int TAG_W     = 16;
	localparam int COORD_W   = 32;
	localparam int NORM_W    = 24;
	localparam int DIST_W    = 51;
	localparam int SUM_W     = 50;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 64'd1);

	// latency of the normalizer and of the distance pipe behind the memory read
	localparam int NORM_LAT  = 3;
	localparam int DRAIN_LAT = 3;

	localparam logic [CFG_W-1:0] SCALE_ONE = 32'h0100_0000;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_A_X_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_Y_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_X_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A_Y_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_X_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B_Y_OFFSET = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_B_X_SCALE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_B_Y_SCALE  = 3'd7;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NORM,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                     valid;
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
		logic [TAG_W-1:0]         edge_tag;
	} ref_entry_t;

	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic                   mem_we;
		logic                   clear_sel;
	} ctrl_t;

endpackage

>>> rtl/nnpm_norm.sv
// coordinate normalizer: (point - offset) * scale, Q24.8 x Q8.24 -> Q8.16
// rounds half away from zero and saturates; three register stages; uses nnpm_pkg
module nnpm_norm (
	input  logic                                clk,
	input  logic signed [nnpm_pkg::COORD_W-1:0] point,
	input  logic signed [nnpm_pkg::COORD_W-1:0] offset,
	input  logic        [nnpm_pkg::CFG_W-1:0]   scale,
	output logic signed [nnpm_pkg::NORM_W-1:0]  norm
);
	import nnpm_pkg::*;

	localparam int MAG_W  = COORD_W + 1;
	localparam int PROD_W = MAG_W + CFG_W;
	localparam int Q_W    = PROD_W - 16 + 1;

	logic signed [MAG_W-1:0]  diff;
	logic [MAG_W-1:0]         mag_s1;
	logic                     neg_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic                     neg_s2;
	logic [Q_W-1:0]           q;
	logic [NORM_W-1:0]        q_pos;
	logic [NORM_W-1:0]        q_neg;
	logic signed [NORM_W-1:0] norm_s3;

	assign diff = MAG_W'(point) - MAG_W'(offset);

	always_ff @(posedge clk) begin
		neg_s1  <= diff[MAG_W-1];
		mag_s1  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		neg_s2  <= neg_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(scale);
		norm_s3 <= neg_s2 ? NORM_W'(-q_neg) : q_pos;
	end

	always_comb begin
		q     = Q_W'(prod_s2[PROD_W-1:16]) + Q_W'(prod_s2[15]);
		q_pos = (q > Q_W'(24'h7F_FFFF)) ? 24'h7F_FFFF : q[NORM_W-1:0];
		q_neg = (q > Q_W'(24'h80_0000)) ? 24'h80_0000 : q[NORM_W-1:0];
	end

	assign norm = norm_s3;

endmodule

>>> rtl/normalized_nearest_point_match_unit.sv
// channel   | transfer when        | carries
// ----------+----------------------+------------------------------------------------
// config    | cfg_we               | cfg_addr, cfg_wdata
// item in   | start && !busy       | func, entry_index, point_x/y, has_edge, edge_tag
// result    | done (one cycle)     | query_tag, matched_edge, found, best_distance_sq
//
// a load runs through the normalizer and then does one memory write; a query
// normalizes, does one reference memory read per entry, drains the distance pipe,
// then raises done. the memory read port sets the scan length.
// after reset busy stays high while the valid bits are cleared.
// results cannot be stalled; done is high for exactly one cycle.
// top level; uses nnpm_pkg and nnpm_norm
module normalized_nearest_point_match_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [nnpm_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic        [nnpm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 func,
	input  logic        [nnpm_pkg::IN_IDX_W-1:0]  entry_index,
	input  logic signed [nnpm_pkg::COORD_W-1:0]   point_x,
	input  logic signed [nnpm_pkg::COORD_W-1:0]   point_y,
	input  logic                                 has_edge,
	input  logic        [nnpm_pkg::TAG_W-1:0]     edge_tag,
	output logic                                 done,
	output logic        [nnpm_pkg::TAG_W-1:0]     query_tag,
	output logic        [nnpm_pkg::TAG_W-1:0]     matched_edge,
	output logic                                 found,
	output logic        [nnpm_pkg::DIST_W-1:0]    best_distance_sq
);
	import nnpm_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam int MAG_W = NORM_W + 1;
	localparam int SQ_W  = 2 * MAG_W;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic signed [CFG_W-1:0] a_x_off_q, a_y_off_q, b_x_off_q, b_y_off_q;
	logic [CFG_W-1:0]        a_x_scl_q, a_y_scl_q, b_x_scl_q, b_y_scl_q;

	logic                        func_q;
	logic [IN_IDX_W-1:0]         idx_q;
	logic signed [COORD_W-1:0]   px_q, py_q;
	logic                        has_edge_q;
	logic [TAG_W-1:0]            tag_q;

	logic [IDX_W-1:0] cnt_q;
	logic [1:0]       wait_q;
	logic             wait_end;
	logic             in_range;

	logic signed [CFG_W-1:0]  off_x, off_y;
	logic [CFG_W-1:0]         scl_x, scl_y;
	logic signed [NORM_W-1:0] nx, ny;

	ref_entry_t       ref_mem_q [ENTRIES];
	ref_entry_t       mem_wdata;
	logic [IDX_W-1:0] mem_waddr;
	ref_entry_t       rd_s1;
	logic             p_s1;

	logic signed [MAG_W-1:0] dx, dy;
	logic [MAG_W-1:0]        mx_s2, my_s2;
	logic                    v_s2;
	logic [TAG_W-1:0]        tag_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic                    v_s3;
	logic [TAG_W-1:0]        tag_s3;
	logic [SUM_W-1:0]        sum;

	logic                    found_q;
	logic [SUM_W-1:0]        best_q;
	logic [TAG_W-1:0]        best_tag_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_x_off_q <= '0;
			a_y_off_q <= '0;
			b_x_off_q <= '0;
			b_y_off_q <= '0;
			a_x_scl_q <= SCALE_ONE;
			a_y_scl_q <= SCALE_ONE;
			b_x_scl_q <= SCALE_ONE;
			b_y_scl_q <= SCALE_ONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_A_X_OFFSET: a_x_off_q <= cfg_wdata;
				REG_A_Y_OFFSET: a_y_off_q <= cfg_wdata;
				REG_A_X_SCALE:  a_x_scl_q <= cfg_wdata;
				REG_A_Y_SCALE:  a_y_scl_q <= cfg_wdata;
				REG_B_X_OFFSET: b_x_off_q <= cfg_wdata;
				REG_B_Y_OFFSET: b_y_off_q <= cfg_wdata;
				REG_B_X_SCALE:  b_x_scl_q <= cfg_wdata;
				REG_B_Y_SCALE:  b_y_scl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured item, held for the whole operation
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q     <= func;
			idx_q      <= entry_index;
			px_q       <= point_x;
			py_q       <= point_y;
			has_edge_q <= has_edge;
			tag_q      <= edge_tag & TAG_MASK;
		end
	end

	always_comb begin
		off_x = (func_q == FUNC_QUERY) ? a_x_off_q : b_x_off_q;
		off_y = (func_q == FUNC_QUERY) ? a_y_off_q : b_y_off_q;
		scl_x = (func_q == FUNC_QUERY) ? a_x_scl_q : b_x_scl_q;
		scl_y = (func_q == FUNC_QUERY) ? a_y_scl_q : b_y_scl_q;
	end

	// output stays stable through the scan while the config registers are not written; the point is held
	nnpm_norm u_norm_x (
		.clk    (clk),
		.point  (px_q),
		.offset (off_x),
		.scale  (scl_x),
		.norm   (nx)
	);

	nnpm_norm u_norm_y (
		.clk    (clk),
		.point  (py_q),
		.offset (off_y),
		.scale  (scl_y),
		.norm   (ny)
	);

	assign wait_end = (wait_q == 2'(NORM_LAT - 1) && state_q == ST_NORM) ||
	                  (wait_q == 2'(DRAIN_LAT - 1) && state_q == ST_DRAIN);
	assign in_range = (32'(idx_q) < 32'(ENTRIES));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (cnt_q == LAST_IDX) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_NORM;
			ST_NORM: begin
				if (wait_end) state_d = (func_q == FUNC_LOAD) ? ST_WRITE : ST_SCAN;
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_SCAN:  if (cnt_q == LAST_IDX) state_d = ST_DRAIN;
			ST_DRAIN: if (wait_end) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_CLEAR: begin
				ctrl.busy      = 1'b1;
				ctrl.mem_we    = 1'b1;
				ctrl.clear_sel = 1'b1;
			end
			ST_IDLE:  ctrl.busy = 1'b0;
			ST_WRITE: begin
				ctrl.busy   = 1'b1;
				ctrl.mem_we = in_range;
			end
			ST_DONE: begin
				ctrl.busy = 1'b1;
				ctrl.done = 1'b1;
			end
			default:  ctrl.busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
			end
			if ((state_q == ST_NORM || state_q == ST_DRAIN) && !wait_end) begin
				wait_q <= wait_q + 2'd1;
			end else begin
				wait_q <= '0;
			end
		end
	end

	// reference memory: one write port, one registered read port
	always_comb begin
		mem_waddr = ctrl.clear_sel ? cnt_q : IDX_W'(idx_q);
		if (ctrl.clear_sel) begin
			mem_wdata = '0;
		end else begin
			mem_wdata.valid    = has_edge_q;
			mem_wdata.x        = nx;
			mem_wdata.y        = ny;
			mem_wdata.edge_tag = tag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_we) begin
			ref_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= ref_mem_q[cnt_q];
	end

	// distance pipe
	assign dx  = MAG_W'(nx) - MAG_W'(rd_s1.x);
	assign dy  = MAG_W'(ny) - MAG_W'(rd_s1.y);
	assign sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);

	always_ff @(posedge clk) begin
		mx_s2  <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		my_s2  <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
		tag_s2 <= rd_s1.edge_tag;
		sqx_s3 <= SQ_W'(mx_s2) * SQ_W'(mx_s2);
		sqy_s3 <= SQ_W'(my_s2) * SQ_W'(my_s2);
		tag_s3 <= tag_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			p_s1 <= (state_q == ST_SCAN);
			v_s2 <= p_s1 && rd_s1.valid;
			v_s3 <= v_s2;
		end
	end

	// running best; strict compare keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_q     <= '0;
			best_tag_q <= '0;
		end else if (start && !busy) begin
			found_q    <= 1'b0;
			best_q     <= '0;
			best_tag_q <= '0;
		end else if (v_s3 && (!found_q || sum < best_q)) begin
			found_q    <= 1'b1;
			best_q     <= sum;
			best_tag_q <= tag_s3;
		end
	end

	assign busy             = ctrl.busy;
	assign done             = ctrl.done;
	assign query_tag        = tag_q;
	assign matched_edge     = best_tag_q;
	assign found            = found_q;
	assign best_distance_sq = DIST_W'(best_q);

endmodule

>>> rtl/nnpm_checker.sv
// port-level checks for normalized_nearest_point_match_unit, bound to the top level
// uses nnpm_pkg for port widths
module nnpm_port_checks (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [nnpm_pkg::TAG_W-1:0]        matched_edge,
	input logic                              found,
	input logic [nnpm_pkg::DIST_W-1:0]       best_distance_sq
);
	import nnpm_pkg::*;

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	// a result only comes while busy, and the block is free right after it
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	// no candidate gives zero edge and zero distance
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (matched_edge == '0 && best_distance_sq == '0))
		else $error("empty match with nonzero payload");

endmodule

bind normalized_nearest_point_match_unit nnpm_port_checks u_nnpm_port_checks (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.matched_edge     (matched_edge),
	.found            (found),
	.best_distance_sq (best_distance_sq)
);

>>> tb/nnpm_checker.sv
// result checker for the normalized nearest point match unit: watches the config,
// item and result channels, keeps its own copy of the point store and predicts each match
// depends on nnpm_pkg
module nnpm_checker
	import nnpm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 func,
	input  logic [IN_IDX_W-1:0]  entry_index,
	input  logic [COORD_W-1:0]   point_x,
	input  logic [COORD_W-1:0]   point_y,
	input  logic                 has_edge,
	input  logic [TAG_W-1:0]     edge_tag,
	input  logic                 done,
	input  logic [TAG_W-1:0]     query_tag,
	input  logic [TAG_W-1:0]     matched_edge,
	input  logic                 found,
	input  logic [DIST_W-1:0]    best_distance_sq,
	output int                   awaiting,
	output int                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [TAG_W-1:0]  q_tag;
		logic [TAG_W-1:0]  m_tag;
		logic              hit;
		logic [DIST_W-1:0] sq_dist;
	} match_t;

	logic [CFG_W-1:0]  regs [8];
	logic [NORM_W-1:0] store_x [ENTRIES];
	logic [NORM_W-1:0] store_y [ENTRIES];
	logic [TAG_W-1:0]  store_tag [ENTRIES];
	bit                store_live [ENTRIES];
	match_t            matches_due [$];
	int                mismatches;

	// (p - off) * scale, Q24.8 x Q8.24, rounded half away from zero to Q8.16, saturated
	function automatic logic [NORM_W-1:0] scale_coord(input logic [COORD_W-1:0] p,
		input logic [COORD_W-1:0] off, input logic [CFG_W-1:0] scale);
		logic signed [COORD_W+1:0] diff;
		logic [COORD_W:0]          mag;
		logic [63:0]               prod;
		logic [63:0]               q;
		diff = $signed({p[COORD_W-1], p[COORD_W-1], p})
			- $signed({off[COORD_W-1], off[COORD_W-1], off});
		mag = (COORD_W+1)'(diff[COORD_W+1] ? -diff : diff);
		prod = 64'(mag) * 64'(scale);
		q = (prod >> 16) + 64'(prod[15]);
		if (!diff[COORD_W+1])
			return (q > 64'h7F_FFFF) ? 24'h7F_FFFF : q[NORM_W-1:0];
		if (q > 64'h80_0000)
			q = 64'h80_0000;
		return 24'(25'h100_0000 - q[NORM_W:0]);
	endfunction

	function automatic longint wide(input logic [NORM_W-1:0] v);
		return {{(64-NORM_W){v[NORM_W-1]}}, v};
	endfunction

	// scan in ascending slot order, strict less-than keeps the lowest slot on a tie
	function automatic match_t nearest(input logic [TAG_W-1:0] tag,
		input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
		match_t r;
		longint qx, qy, dx, dy, d;
		r = '0;
		r.q_tag = tag;
		qx = wide(scale_coord(px, regs[REG_A_X_OFFSET], regs[REG_A_X_SCALE]));
		qy = wide(scale_coord(py, regs[REG_A_Y_OFFSET], regs[REG_A_Y_SCALE]));
		for (int i = 0; i < ENTRIES; i++) begin
			if (store_live[i]) begin
				dx = qx - wide(store_x[i]);
				dy = qy - wide(store_y[i]);
				if (dx < 0)
					dx = -dx;
				if (dy < 0)
					dy = -dy;
				d = dx * dx + dy * dy;
				if (!r.hit || d < longint'(r.sq_dist)) begin
					r.hit = 1'b1;
					r.sq_dist = d[DIST_W-1:0];
					r.m_tag = store_tag[i];
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		match_t want;
		if (!arst_n) begin
			regs[REG_A_X_OFFSET] = '0;
			regs[REG_A_Y_OFFSET] = '0;
			regs[REG_A_X_SCALE]  = SCALE_ONE;
			regs[REG_A_Y_SCALE]  = SCALE_ONE;
			regs[REG_B_X_OFFSET] = '0;
			regs[REG_B_Y_OFFSET] = '0;
			regs[REG_B_X_SCALE]  = SCALE_ONE;
			regs[REG_B_Y_SCALE]  = SCALE_ONE;
			for (int i = 0; i < ENTRIES; i++)
				store_live[i] = 1'b0;
			matches_due.delete();
			mismatches = 0;
			awaiting <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (matches_due.size() == 0) begin
					$display("%0t unexpected result: expected none, got query_tag %h",
						$time, query_tag);
					mismatches++;
				end else begin
					want = matches_due.pop_front();
					if (query_tag !== want.q_tag) begin
						$display("%0t query_tag: expected %h, got %h",
							$time, want.q_tag, query_tag);
						mismatches++;
					end
					if (matched_edge !== want.m_tag) begin
						$display("%0t matched_edge: expected %h, got %h",
							$time, want.m_tag, matched_edge);
						mismatches++;
					end
					if (found !== want.hit) begin
						$display("%0t found: expected %b, got %b", $time, want.hit, found);
						mismatches++;
					end
					if (best_distance_sq !== want.sq_dist) begin
						$display("%0t best_distance_sq: expected %h, got %h",
							$time, want.sq_dist, best_distance_sq);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				regs[cfg_addr] = cfg_wdata;
			if (start && !busy) begin
				if (func == FUNC_LOAD) begin
					if (entry_index < ENTRIES) begin
						store_x[entry_index] =
							scale_coord(point_x, regs[REG_B_X_OFFSET], regs[REG_B_X_SCALE]);
						store_y[entry_index] =
							scale_coord(point_y, regs[REG_B_Y_OFFSET], regs[REG_B_Y_SCALE]);
						store_tag[entry_index] = edge_tag & TAG_MASK;
						store_live[entry_index] = has_edge;
					end
				end else begin
					matches_due = {matches_due, nearest(edge_tag & TAG_MASK, point_x, point_y)};
				end
			end
			awaiting <= matches_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

>>> tb/tb_normalized_nearest_point_match_unit.sv
// testbench top for normalized_nearest_point_match_unit: directed and random loads and
// queries over several register settings; depends on nnpm_pkg, nnpm_checker and the rtl
module tb_normalized_nearest_point_match_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import nnpm_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_addr;
	logic [CFG_W-1:0]           cfg_wdata;
	logic                       start;
	logic                       busy;
	logic                       func;
	logic [IN_IDX_W-1:0]        entry_index;
	logic signed [COORD_W-1:0]  point_x;
	logic signed [COORD_W-1:0]  point_y;
	logic                       has_edge;
	logic [TAG_W-1:0]           edge_tag;
	logic                       done;
	logic [TAG_W-1:0]           query_tag;
	logic [TAG_W-1:0]           matched_edge;
	logic                       found;
	logic [DIST_W-1:0]          best_distance_sq;
	int                         awaiting;
	int                         fail_count;

	logic [CFG_W-1:0]           cfg_next [8];
	logic signed [COORD_W-1:0]  pool_x [8];
	logic signed [COORD_W-1:0]  pool_y [8];
	int                         burst_left;

	normalized_nearest_point_match_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.entry_index      (entry_index),
		.point_x          (point_x),
		.point_y          (point_y),
		.has_edge         (has_edge),
		.edge_tag         (edge_tag),
		.done             (done),
		.query_tag        (query_tag),
		.matched_edge     (matched_edge),
		.found            (found),
		.best_distance_sq (best_distance_sq)
	);

	nnpm_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.entry_index      (entry_index),
		.point_x          (point_x),
		.point_y          (point_y),
		.has_edge         (has_edge),
		.edge_tag         (edge_tag),
		.done             (done),
		.query_tag        (query_tag),
		.matched_edge     (matched_edge),
		.found            (found),
		.best_distance_sq (best_distance_sq),
		.awaiting         (awaiting),
		.fail_count       (fail_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	// one item transfer; a new burst starts after a random gap
	task automatic push_item(input logic op, input logic [IN_IDX_W-1:0] slot,
		input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
		input logic edge_on, input logic [TAG_W-1:0] tag);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
		burst_left--;
		start <= 1'b1;
		func <= op;
		entry_index <= slot;
		point_x <= px;
		point_y <= py;
		has_edge <= edge_on;
		edge_tag <= tag;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// hold off until every query has answered and the block is idle
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (awaiting != 0 || busy !== 1'b0);
		repeat (NORM_LAT + DRAIN_LAT + 2) @(posedge clk);
	endtask

	task automatic apply_config();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= CFG_IDX_W'(i);
			cfg_wdata <= cfg_next[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [COORD_W-1:0] spread(input int lo, input int hi);
		logic signed [COORD_W-1:0] v;
		v = $urandom;
		return v >>> $urandom_range(lo, hi);
	endfunction

	function automatic logic [CFG_W-1:0] pick_scale();
		case ($urandom_range(0, 7))
			0:       return $urandom;
			1, 2:    return SCALE_ONE << $urandom_range(1, 4);
			default: return (SCALE_ONE >> $urandom_range(0, 12)) + $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_offset();
		return ($urandom_range(0, 3) == 0) ? $urandom : spread(6, 20);
	endfunction

	// mostly near a few cluster centers, so ties and close calls show up
	function automatic logic signed [COORD_W-1:0] pick_coord(
		input logic signed [COORD_W-1:0] base);
		case ($urandom_range(0, 9))
			0, 1:          return $urandom;
			2, 3, 4, 5, 6: return base + COORD_W'($urandom_range(0, 512)) - 32'sd256;
			default:       return base;
		endcase
	endfunction

	task automatic pick_phase(input int phase);
		case (phase)
			0: begin
				cfg_next[REG_A_X_OFFSET] = 32'h7FFF_FFFF;
				cfg_next[REG_A_Y_OFFSET] = 32'h7FFF_FFFF;
				cfg_next[REG_A_X_SCALE]  = 32'hFFFF_FFFF;
				cfg_next[REG_A_Y_SCALE]  = 32'hFFFF_FFFF;
				cfg_next[REG_B_X_OFFSET] = 32'h8000_0000;
				cfg_next[REG_B_Y_OFFSET] = 32'h8000_0000;
				cfg_next[REG_B_X_SCALE]  = '0;
				cfg_next[REG_B_Y_SCALE]  = '0;
			end
			1: begin
				cfg_next[REG_A_X_OFFSET] = 32'h8000_0000;
				cfg_next[REG_A_Y_OFFSET] = 32'h8000_0000;
				cfg_next[REG_A_X_SCALE]  = '0;
				cfg_next[REG_A_Y_SCALE]  = '0;
				cfg_next[REG_B_X_OFFSET] = 32'h7FFF_FFFF;
				cfg_next[REG_B_Y_OFFSET] = 32'h7FFF_FFFF;
				cfg_next[REG_B_X_SCALE]  = 32'hFFFF_FFFF;
				cfg_next[REG_B_Y_SCALE]  = 32'hFFFF_FFFF;
			end
			2: begin
				cfg_next[REG_A_X_OFFSET] = '0;
				cfg_next[REG_A_Y_OFFSET] = '0;
				cfg_next[REG_A_X_SCALE]  = SCALE_ONE;
				cfg_next[REG_A_Y_SCALE]  = SCALE_ONE;
				cfg_next[REG_B_X_OFFSET] = '0;
				cfg_next[REG_B_Y_OFFSET] = '0;
				cfg_next[REG_B_X_SCALE]  = SCALE_ONE;
				cfg_next[REG_B_Y_SCALE]  = SCALE_ONE;
			end
			default: begin
				cfg_next[REG_A_X_OFFSET] = pick_offset();
				cfg_next[REG_A_Y_OFFSET] = pick_offset();
				cfg_next[REG_A_X_SCALE]  = pick_scale();
				cfg_next[REG_A_Y_SCALE]  = pick_scale();
				cfg_next[REG_B_X_OFFSET] = pick_offset();
				cfg_next[REG_B_Y_OFFSET] = pick_offset();
				cfg_next[REG_B_X_SCALE]  = pick_scale();
				cfg_next[REG_B_Y_SCALE]  = pick_scale();
			end
		endcase
		for (int k = 0; k < 8; k++) begin
			pool_x[k] = spread(6, 24);
			pool_y[k] = spread(6, 24);
		end
	endtask

	initial begin : stimulus
		int count;
		int k;
		logic [IN_IDX_W-1:0] slot;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		func = FUNC_LOAD;
		entry_index = '0;
		point_x = '0;
		point_y = '0;
		has_edge = 1'b0;
		edge_tag = '0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// valid bits are cleared after reset
		do @(posedge clk); while (busy !== 1'b0);

		// empty store, then a tie at the origin, an edgeless load and both saturation corners
		push_item(FUNC_QUERY, 10'h3FF, 32'sd0, 32'sd0, 1'b1, 16'h0000);
		push_item(FUNC_LOAD, 10'd0, 32'sd0, 32'sd0, 1'b1, 16'h0001);
		push_item(FUNC_LOAD, 10'd3, 32'sd0, 32'sd0, 1'b1, 16'h5555);
		push_item(FUNC_LOAD, 10'd7, 32'sh100, 32'sh100, 1'b0, 16'hAAAA);
		push_item(FUNC_LOAD, 10'h3FF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 16'hFFFF);
		push_item(FUNC_LOAD, 10'd5, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'h1234);
		push_item(FUNC_LOAD, 10'd9, 32'sh40, -32'sh40, 1'b1, 16'h00F0);
		push_item(FUNC_QUERY, 10'd0, 32'sd0, 32'sd0, 1'b0, 16'hFFFF);
		push_item(FUNC_QUERY, 10'h155, 32'sh100, 32'sh100, 1'b1, 16'h8001);
		push_item(FUNC_QUERY, 10'h2AA, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'h7FFF);
		push_item(FUNC_QUERY, 10'h3FF, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'h00FF);
		push_item(FUNC_QUERY, 10'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 16'hFF00);
		push_item(FUNC_LOAD, 10'd0, 32'sd0, 32'sd0, 1'b0, 16'h0002);
		push_item(FUNC_QUERY, 10'd0, 32'sd0, 32'sd0, 1'b1, 16'h0F0F);
		push_item(FUNC_LOAD, 10'd3, 32'sh10, 32'sd0, 1'b1, 16'h0333);
		push_item(FUNC_QUERY, 10'd3, 32'sd0, 32'sd0, 1'b0, 16'hF0F0);
		push_item(FUNC_QUERY, 10'd0, -32'sh1, 32'sh1, 1'b1, 16'h3C3C);

		for (int phase = 0; phase < 7; phase++) begin
			settle();
			pick_phase(phase);
			apply_config();
			count = (phase < 2) ? 40 : 80;
			for (int i = 0; i < count; i++) begin
				k = $urandom_range(0, 7);
				slot = ($urandom_range(0, 9) < 7) ? IN_IDX_W'($urandom_range(0, 31))
					: IN_IDX_W'($urandom_range(0, 1023));
				push_item(($urandom_range(0, 9) < 4) ? FUNC_QUERY : FUNC_LOAD, slot,
					pick_coord(pool_x[k]), pick_coord(pool_y[k]),
					$urandom_range(0, 4) != 0, TAG_W'($urandom));
			end
		end

		settle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
